### rtl/aes_pkg.sv
package aes_pkg;

    localparam int BLOCK_W    = 128;
    localparam int HALF_W     = 64;
    localparam int KEY_DEPTH  = 15;
    localparam int KEY_IDX_W  = 4;
    localparam int NR_128     = 128 / 32 + 6;
    localparam int NR_192     = 192 / 32 + 6;
    localparam int NR_256     = 256 / 32 + 6;

    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_ENC  = 2'd1;
    localparam logic [1:0] REQ_DEC  = 2'd2;
    localparam logic [1:0] REQ_NONE = 2'd3;

    localparam logic [1:0] KS_128 = 2'd0;
    localparam logic [1:0] KS_192 = 2'd1;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[a];
    endfunction

endpackage

### rtl/aes_round.sv
module aes_round (
    input  logic [127:0] state_in,
    input  logic [127:0] round_key,
    input  logic         decrypt,
    input  logic         skip_mix,
    output logic [127:0] state_out
);
    import aes_pkg::*;

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    logic [7:0] s   [16];
    logic [7:0] sh  [16];
    logic [7:0] sb  [16];
    logic [7:0] ak  [16];
    logic [7:0] mx  [16];
    logic [7:0] fm  [16];

    // byte k is state[k mod 4][k / 4], byte 0 in the top bits
    always_comb
    begin
        for (int k = 0; k < 16; k++)
        begin
            s[k] = state_in[127 - 8*k -: 8];
        end
    end

    // encrypt: sub, shift, mix, key; decrypt: shift, sub, key, mix
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                if (decrypt)
                begin
                    sh[r + 4*((c + r) % 4)] = inv_sbox(s[r + 4*c]);
                end
                else
                begin
                    sh[r + 4*c] = sbox(s[r + 4*((c + r) % 4)]);
                end
            end
        end
        for (int k = 0; k < 16; k++)
        begin
            sb[k] = sh[k];
        end
    end

    // mix columns on one source, key before mix when decrypting
    always_comb
    begin
        logic [7:0] a0, a1, a2, a3, x0, x1, x2, x3, y0, y1, y2, y3;
        for (int k = 0; k < 16; k++)
        begin
            ak[k] = sb[k] ^ round_key[127 - 8*k -: 8];
        end
        for (int c = 0; c < 4; c++)
        begin
            if (decrypt)
            begin
                a0 = ak[4*c]; a1 = ak[4*c+1]; a2 = ak[4*c+2]; a3 = ak[4*c+3];
            end
            else
            begin
                a0 = sb[4*c]; a1 = sb[4*c+1]; a2 = sb[4*c+2]; a3 = sb[4*c+3];
            end
            // forward: 2a ^ 3b ^ c ^ d
            x0 = xt(a0); x1 = xt(a1); x2 = xt(a2); x3 = xt(a3);
            if (decrypt)
            begin
                // inverse via 4-fold pre-step: y0 = xt(xt(a0^a2)), y1 = xt(xt(a1^a3))
                y0 = xt(xt(a0 ^ a2));
                y1 = xt(xt(a1 ^ a3));
                a0 = a0 ^ y0; a2 = a2 ^ y0;
                a1 = a1 ^ y1; a3 = a3 ^ y1;
                x0 = xt(a0); x1 = xt(a1); x2 = xt(a2); x3 = xt(a3);
            end
            y0 = x0 ^ x1 ^ a1 ^ a2 ^ a3;
            y1 = a0 ^ x1 ^ x2 ^ a2 ^ a3;
            y2 = a0 ^ a1 ^ x2 ^ x3 ^ a3;
            y3 = x0 ^ a0 ^ a1 ^ a2 ^ x3;
            mx[4*c] = y0; mx[4*c+1] = y1; mx[4*c+2] = y2; mx[4*c+3] = y3;
        end
        for (int k = 0; k < 16; k++)
        begin
            if (skip_mix)
            begin
                fm[k] = ak[k];
            end
            else if (decrypt)
            begin
                fm[k] = mx[k];
            end
            else
            begin
                fm[k] = mx[k] ^ round_key[127 - 8*k -: 8];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 16; k++)
        begin
            state_out[127 - 8*k -: 8] = fm[k];
        end
    end

endmodule

### rtl/aes_block_cipher_top.sv
// a block request runs the first key add in ST_FIRST, then 10, 12 or 14 rounds in ST_ROUND
// a new block request is taken only after the previous block has gone to the output register
// the single read port of the key memory gives one round key per cycle
// a load request writes the key memory and gives no result
// reset clears control state, the output register and key_size; the key memory is not cleared
module aes_block_cipher_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [3:0]  round_index,
    input  logic [63:0] data_hi,
    input  logic [63:0] data_lo,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] out_hi,
    output logic [63:0] out_lo
);
    import aes_pkg::*;

    typedef enum logic [1:0] { ST_IDLE, ST_FIRST, ST_ROUND, ST_DONE } st_t;

    st_t          st_reg;
    logic [1:0]   ks_reg;
    logic         dec_reg;
    logic [3:0]   rnd_reg;
    logic [3:0]   nr_reg;
    logic [127:0] blk_reg;
    logic [127:0] out_blk_reg;
    logic         out_valid_reg;
    logic [127:0] mem_q;
    logic [127:0] key_mem [KEY_DEPTH];
    logic [3:0]   rd_addr;
    logic [127:0] rnd_out;
    logic         fire;
    logic [3:0]   nr_now;
    logic         out_load;
    logic [127:0] out_load_blk;

    assign in_ready  = (st_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_hi    = out_blk_reg[127:64];
    assign out_lo    = out_blk_reg[63:0];
    assign fire      = in_valid && in_ready;

    always_comb
    begin
        unique case (ks_reg)
            KS_128:  nr_now = 4'(NR_128);
            KS_192:  nr_now = 4'(NR_192);
            default: nr_now = 4'(NR_256);
        endcase
    end

    // key memory read address: first key on request, then the next round
    always_comb
    begin
        if (st_reg == ST_IDLE)
        begin
            rd_addr = (req_type == REQ_DEC) ? nr_now : 4'd0;
        end
        else
        begin
            rd_addr = dec_reg ? (nr_reg - rnd_reg - 4'd1) : (rnd_reg + 4'd1);
        end
    end

    // key memory
    always_ff @(posedge clk)
    begin
        if (fire && req_type == REQ_LOAD && round_index != 4'd15)
        begin
            key_mem[round_index] <= {data_hi, data_lo};
        end
        mem_q <= key_mem[rd_addr];
    end

    aes_round u_round (
        .state_in  (blk_reg),
        .round_key (mem_q),
        .decrypt   (dec_reg),
        .skip_mix  (dec_reg ? (rnd_reg == nr_reg) : (rnd_reg == nr_reg)),
        .state_out (rnd_out)
    );

    // hand the finished block to the output register when it is free
    always_comb
    begin
        out_load     = ((st_reg == ST_ROUND && rnd_reg == nr_reg) || st_reg == ST_DONE)
                       && (!out_valid_reg || out_ready);
        out_load_blk = (st_reg == ST_DONE) ? blk_reg : rnd_out;
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            ks_reg        <= KS_128;
            dec_reg       <= 1'b0;
            rnd_reg       <= 4'd0;
            nr_reg        <= 4'd0;
            out_valid_reg <= 1'b0;
            out_blk_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                ks_reg <= cfg_wdata;
            end
            // output register
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_blk_reg   <= out_load_blk;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (st_reg)
                ST_IDLE:
                begin
                    if (fire && (req_type == REQ_ENC || req_type == REQ_DEC))
                    begin
                        st_reg  <= ST_FIRST;
                        dec_reg <= (req_type == REQ_DEC);
                        nr_reg  <= nr_now;
                        rnd_reg <= 4'd0;
                    end
                end
                ST_FIRST:
                begin
                    st_reg  <= ST_ROUND;
                    rnd_reg <= 4'd1;
                end
                ST_ROUND:
                begin
                    if (rnd_reg == nr_reg)
                    begin
                        st_reg <= out_load ? ST_IDLE : ST_DONE;
                    end
                    else
                    begin
                        rnd_reg <= rnd_reg + 4'd1;
                    end
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        st_reg <= ST_IDLE;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    // block register
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            blk_reg <= {data_hi, data_lo};
        end
        else if (st_reg == ST_FIRST)
        begin
            blk_reg <= blk_reg ^ mem_q;
        end
        else if (st_reg == ST_ROUND)
        begin
            blk_reg <= rnd_out;
        end
    end

    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_DONE) |-> out_valid) else $error("finished block without full output");
    a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_ROUND) |-> (rnd_reg <= nr_reg && rnd_reg != 4'd0))
        else $error("round counter out of range");
    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(out_blk_reg))
        else $error("result lost");

endmodule

### verif/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import aes_pkg::*;

    localparam logic [1:0] KS_256 = 2'd2;
    localparam logic [1:0] KS_ODD = 2'd3;
    localparam int STALL_LIMIT    = 3000;
    localparam int SETTLE_CYCLES  = 24;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_ITEMS    = 155;

    localparam logic [127:0] FIPS_PT  = 128'h00112233445566778899aabbccddeeff;
    localparam logic [127:0] FIPS_128 = 128'h69c4e0d86a7b0430d8cdb78070b4c55a;
    localparam logic [127:0] FIPS_192 = 128'hdda97ca4864cdfe06eaf70a0ec0d7191;
    localparam logic [127:0] FIPS_256 = 128'h8ea2b7ca516745bfeafc49904b496089;
    localparam logic [127:0] ONES     = {128{1'b1}};

    typedef struct {
        logic [1:0]   ks;
        logic [1:0]   req;
        logic [3:0]   idx;
        logic [127:0] blk;
        bit           typed;
        logic [127:0] want;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  req_type;
    logic [3:0]  round_index;
    logic [63:0] data_hi;
    logic [63:0] data_lo;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] out_hi;
    logic [63:0] out_lo;

    // predictor state
    logic [7:0]   fwd_sb [256];
    logic [7:0]   inv_sb [256];
    logic [127:0] round_keys [15];
    logic [1:0]   cur_ks;
    logic [127:0] blocks_due [$];

    int  errors;
    int  blocks_seen;
    int  idle_run;
    bit  quiet;
    int  hold_left;
    bit  held;
    int  enc_n, dec_n, load_n;

    dir_row_t dir_tab [18];

    aes_block_cipher_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .round_index (round_index),
        .data_hi     (data_hi),
        .data_lo     (data_lo),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_hi      (out_hi),
        .out_lo      (out_lo)
    );

    always #6 clk = ~clk;

    // galois field arithmetic
    function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    function automatic logic [7:0] byte_at(input logic [127:0] v, input int k);
        return v[127 - 8 * k -: 8];
    endfunction

    function automatic logic [127:0] sub_block(input logic [127:0] v, input bit inv);
        logic [127:0] r;
        for (int k = 0; k < 16; k++)
            r[127 - 8 * k -: 8] = inv ? inv_sb[byte_at(v, k)] : fwd_sb[byte_at(v, k)];
        return r;
    endfunction

    // byte (row, col) sits at index row + 4 * col
    function automatic logic [127:0] shift_block(input logic [127:0] v, input bit inv);
        logic [127:0] r;
        int src;
        for (int row = 0; row < 4; row++)
            for (int col = 0; col < 4; col++)
            begin
                src = (col + row) & 3;
                if (inv)
                    r[127 - 8 * (row + 4 * src) -: 8] = byte_at(v, row + 4 * col);
                else
                    r[127 - 8 * (row + 4 * col) -: 8] = byte_at(v, row + 4 * src);
            end
        return r;
    endfunction

    function automatic logic [127:0] mix_block(input logic [127:0] v, input bit inv);
        logic [7:0]   coef [4];
        logic [7:0]   acc;
        logic [127:0] r;
        if (inv)
            coef = '{8'd14, 8'd11, 8'd13, 8'd9};
        else
            coef = '{8'd2, 8'd3, 8'd1, 8'd1};
        for (int col = 0; col < 4; col++)
            for (int row = 0; row < 4; row++)
            begin
                acc = 8'h00;
                for (int j = 0; j < 4; j++)
                    acc ^= gf_mult(coef[(j - row) & 3], byte_at(v, 4 * col + j));
                r[127 - 8 * (4 * col + row) -: 8] = acc;
            end
        return r;
    endfunction

    // full cipher or inverse cipher with the stored round keys
    function automatic logic [127:0] aes_predict(input logic [1:0] req, input logic [127:0] d);
        int nr;
        logic [127:0] s;
        nr = (cur_ks == KS_128) ? NR_128 : ((cur_ks == KS_192) ? NR_192 : NR_256);
        if (req == REQ_ENC)
        begin
            s = d ^ round_keys[0];
            for (int rnd = 1; rnd <= nr; rnd++)
            begin
                s = shift_block(sub_block(s, 0), 0);
                if (rnd != nr)
                    s = mix_block(s, 0);
                s ^= round_keys[rnd];
            end
        end
        else
        begin
            s = d ^ round_keys[nr];
            for (int rnd = nr - 1; rnd >= 0; rnd--)
            begin
                s = sub_block(shift_block(s, 1), 1) ^ round_keys[rnd];
                if (rnd != 0)
                    s = mix_block(s, 1);
            end
        end
        return s;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // one request through the input handshake, prediction on acceptance
    task automatic send_request(input logic [1:0] req, input logic [3:0] idx,
                                input logic [127:0] d, input bit typed,
                                input logic [127:0] want);
        while (!quiet && $urandom_range(99) < 13)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= req;
        round_index <= idx;
        data_hi     <= d[127:64];
        data_lo     <= d[63:0];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        case (req)
            REQ_LOAD:
            begin
                load_n++;
                if (idx < KEY_DEPTH)
                    round_keys[idx] = d;
            end
            REQ_ENC, REQ_DEC:
            begin
                if (req == REQ_ENC)
                    enc_n++;
                else
                    dec_n++;
                blocks_due.push_back(typed ? want : aes_predict(req, d));
            end
            default: ;
        endcase
    endtask

    task automatic drain_results;
        in_valid <= 1'b0;
        @(posedge clk);
        while (blocks_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_key_size(input logic [1:0] ks);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= ks;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_ks     = ks;
    endtask

    // standard key schedule, all 15 round keys loaded
    task automatic load_schedule(input int nk, input logic [255:0] key);
        logic [31:0] w [60];
        logic [31:0] t;
        logic [7:0]  rc;
        rc = 8'h01;
        for (int i = 0; i < nk; i++)
            w[i] = key[255 - 32 * i -: 32];
        for (int i = nk; i < 60; i++)
        begin
            t = w[i - 1];
            if (i % nk == 0)
            begin
                t = {t[23:0], t[31:24]};
                t = {fwd_sb[t[31:24]], fwd_sb[t[23:16]], fwd_sb[t[15:8]], fwd_sb[t[7:0]]};
                t ^= {rc, 24'h0};
                rc = gf_mult(rc, 8'h02);
            end
            else if (nk > 6 && i % nk == 4)
                t = {fwd_sb[t[31:24]], fwd_sb[t[23:16]], fwd_sb[t[15:8]], fwd_sb[t[7:0]]};
            w[i] = w[i - nk] ^ t;
        end
        for (int r = 0; r < KEY_DEPTH; r++)
            send_request(REQ_LOAD, r[3:0], {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]},
                         1'b0, '0);
    endtask

    // result side: random back-pressure, one long hold, checking
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                blocks_seen++;
                if (blocks_due.size() == 0)
                begin
                    report_mismatch("unexpected out_hi", out_hi, '0);
                end
                else
                begin
                    if (out_hi !== blocks_due[0][127:64])
                        report_mismatch("out_hi", out_hi, blocks_due[0][127:64]);
                    if (out_lo !== blocks_due[0][63:0])
                        report_mismatch("out_lo", out_lo, blocks_due[0][63:0]);
                    void'(blocks_due.pop_front());
                end
            end
            if (!held && blocks_seen == 150)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 13);
        end
    end

    // watchdog on cycles without any handshake or configuration write
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            idle_run <= 0;
        else if (idle_run >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_run <= idle_run + 1;
    end

    // stimulus
    initial
    begin
        logic [1:0]   phase_ks [6];
        logic [1:0]   req;
        logic [127:0] d;
        int           pick;
        int           n;
        logic [7:0]   x, p;

        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = KS_128;
        in_valid    = 1'b0;
        req_type    = REQ_LOAD;
        round_index = '0;
        data_hi     = '0;
        data_lo     = '0;
        out_ready   = 1'b0;
        errors      = 0;
        blocks_seen = 0;
        idle_run    = 0;
        quiet       = 1'b0;
        hold_left   = 0;
        held        = 1'b0;
        enc_n       = 0;
        dec_n       = 0;
        load_n      = 0;
        cur_ks      = KS_128;

        // s-box from the field inverse and the affine map
        for (int a = 0; a < 256; a++)
        begin
            p = 8'h01;
            x = a[7:0];
            for (int e = 0; e < 8; e++)
            begin
                if (e != 0)
                    p = gf_mult(p, x);
                x = gf_mult(x, x);
            end
            x = (a == 0) ? 8'h00 : p;
            p = x ^ {x[6:0], x[7]} ^ {x[5:0], x[7:6]} ^ {x[4:0], x[7:5]}
                  ^ {x[3:0], x[7:4]} ^ 8'h63;
            fwd_sb[a] = p;
            inv_sb[p] = a[7:0];
        end

        dir_tab = '{
            '{KS_128, REQ_ENC,  4'd0,  FIPS_PT,  1'b1, FIPS_128},
            '{KS_128, REQ_DEC,  4'd0,  FIPS_128, 1'b1, FIPS_PT},
            '{KS_128, REQ_ENC,  4'd0,  '0,       1'b0, '0},
            '{KS_128, REQ_ENC,  4'd15, ONES,     1'b0, '0},
            '{KS_128, REQ_DEC,  4'd0,  '0,       1'b0, '0},
            '{KS_128, REQ_DEC,  4'd0,  ONES,     1'b0, '0},
            '{KS_128, REQ_NONE, 4'd15, ONES,     1'b0, '0},
            '{KS_128, REQ_LOAD, 4'd15, ONES,     1'b0, '0},
            '{KS_128, REQ_ENC,  4'd0,  FIPS_PT,  1'b1, FIPS_128},
            '{KS_192, REQ_ENC,  4'd0,  FIPS_PT,  1'b1, FIPS_192},
            '{KS_192, REQ_DEC,  4'd0,  FIPS_192, 1'b1, FIPS_PT},
            '{KS_192, REQ_ENC,  4'd0,  ONES,     1'b0, '0},
            '{KS_256, REQ_ENC,  4'd0,  FIPS_PT,  1'b1, FIPS_256},
            '{KS_256, REQ_DEC,  4'd0,  FIPS_256, 1'b1, FIPS_PT},
            '{KS_256, REQ_DEC,  4'd0,  ONES,     1'b0, '0},
            '{KS_ODD, REQ_ENC,  4'd0,  FIPS_PT,  1'b1, FIPS_256},
            '{KS_ODD, REQ_DEC,  4'd0,  FIPS_256, 1'b1, FIPS_PT},
            '{KS_ODD, REQ_ENC,  4'd0,  '0,       1'b0, '0}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, key schedule reloaded on every key size change
        for (int i = 0; i < $size(dir_tab); i++)
        begin
            if (i == 0 || dir_tab[i].ks != cur_ks)
            begin
                write_key_size(dir_tab[i].ks);
                case (dir_tab[i].ks)
                    KS_128:  load_schedule(4, {128'h000102030405060708090a0b0c0d0e0f,
                                               128'h0});
                    KS_192:  load_schedule(6, {192'h000102030405060708090a0b0c0d0e0f1011121314151617,
                                               64'h0});
                    default: load_schedule(8, {128'h000102030405060708090a0b0c0d0e0f,
                                               128'h101112131415161718191a1b1c1d1e1f});
                endcase
            end
            send_request(dir_tab[i].req, dir_tab[i].idx, dir_tab[i].blk,
                         dir_tab[i].typed, dir_tab[i].want);
        end

        // random part over several key sizes
        phase_ks = '{KS_128, KS_256, KS_192, KS_ODD, KS_128, KS_256};
        for (int ph = 0; ph < 6; ph++)
        begin
            write_key_size(phase_ks[ph]);
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                quiet = (ph == 2 && n >= 40 && n < 140);
                if (ph == 1 && n == 80)
                    drain_results();
                pick = $urandom_range(99);
                req  = (pick < 40) ? REQ_ENC : (pick < 80) ? REQ_DEC :
                       (pick < 95) ? REQ_LOAD : REQ_NONE;
                case ($urandom_range(19))
                    0:       d = '0;
                    1:       d = ONES;
                    default: d = {$urandom, $urandom, $urandom, $urandom};
                endcase
                send_request(req, 4'($urandom_range(15)), d, 1'b0, '0);
                if (req != REQ_NONE)
                    n++;
            end
        end
        quiet = 1'b0;

        drain_results();
        $display("covered %0d encryptions, %0d decryptions, %0d key loads", enc_n, dec_n, load_n);
        $display("key sizes 128, 192, 256 and the unused code, with long output stall");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
